### hw/rtl/pbpc_pkg.sv
// ----------------------------------------------------------------------------
// pbpc_pkg
// Shared types, codes and defaults of the port bind permission checker.
// ----------------------------------------------------------------------------
package pbpc_pkg;

  // default table capacity
  localparam int unsigned DEF_MAX_RULES = 64;

  // request codes
  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DENIED   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // socket kind on a check
  localparam logic [1:0] KIND_DGRAM  = 2'd0;
  localparam logic [1:0] KIND_STREAM = 2'd1;

  // rule protocol on an append
  localparam logic [1:0] RPROTO_ANY = 2'd0;
  localparam logic [1:0] RPROTO_TCP = 2'd1;
  localparam logic [1:0] RPROTO_UDP = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CFG_POLICY_EN     = 8'd0;
  localparam logic [7:0] CFG_PRIV_EXEMPT   = 8'd1;
  localparam logic [7:0] CFG_AUTO_EXEMPT   = 8'd2;
  localparam logic [7:0] CFG_HIGHEST_PORT  = 8'd3;

  localparam logic [15:0] HIGHEST_PORT_RESET = 16'd1023;
  localparam logic [31:0] JAIL_UNJAILED_ONLY = 32'hFFFF_FFFF;
  localparam logic [31:0] JAIL_ANY           = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         proto_kind;
    logic [15:0]        port;
    logic signed [31:0] jail_sel;
    logic [31:0]        subject_id;
    logic               id_kind;
    logic [31:0]        group_id;
    logic [31:0]        extra_group_id;
    logic               addr_family_ok;
    logic               low_port_required;
    logic               has_bind_privilege;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] rules_held;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] value;
  } cfg_item_t;

  // one stored rule
  typedef struct packed {
    logic [1:0]  proto;
    logic        is_group;
    logic [15:0] port;
    logic [31:0] jail;
    logic [31:0] subject;
  } rule_t;

  localparam int unsigned RULE_W = $bits(rule_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

endpackage

### hw/rtl/pbpc_stream_if.sv
// ----------------------------------------------------------------------------
// pbpc_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface pbpc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/port_bind_permission_check.sv
// Append, clear and checks settled before the table scan pass from the input
//   transfer through the status register into the output register.
// A scanning check passes one rule per cycle through the single read port of
//   the rule RAM into the compare unit.
// One item at a time: input ready is low from transfer until the result is staged.
// Reset: registers return to 1, 1, 1, 1023 and the table is empty at once.
// ----------------------------------------------------------------------------
// port_bind_permission_check
// Ordered port-grant rule table with append, clear and bind-check requests.
// ----------------------------------------------------------------------------
module port_bind_permission_check #(
  parameter int unsigned MaxRules = pbpc_pkg::DEF_MAX_RULES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pbpc_stream_if.sink   in_i,
  pbpc_stream_if.source out_o,
  pbpc_stream_if.sink   cfg_i
);
  import pbpc_pkg::*;

  localparam int unsigned AddrW = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int unsigned CntW  = $clog2(MaxRules + 1);

  state_e state_q, state_d;

  logic            policy_en_q, priv_exempt_q, auto_exempt_q;
  logic [15:0]     highest_port_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic            cmp_vld_q;
  in_item_t        req_q;
  logic [1:0]      status_q;
  logic            out_vld_q;
  out_item_t       out_q;

  in_item_t        in_d;
  logic            in_xfer;
  logic            in_ready;
  logic            out_load;
  logic            table_full;
  logic            pre_done;
  logic [1:0]      pre_status;
  logic            ram_we;
  rule_t           wr_rule;
  rule_t           rd_rule;
  logic            hit;
  logic            scan_last;
  logic [1:0]      fallback;

  assign in_d      = in_i.data;
  assign in_xfer   = in_i.valid && in_ready;
  assign table_full = (cnt_q >= CntW'(MaxRules));

  // configuration, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_en_q    <= 1'b1;
      priv_exempt_q  <= 1'b1;
      auto_exempt_q  <= 1'b1;
      highest_port_q <= HIGHEST_PORT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_POLICY_EN:    policy_en_q    <= cfg_i.data.value[0];
        CFG_PRIV_EXEMPT:  priv_exempt_q  <= cfg_i.data.value[0];
        CFG_AUTO_EXEMPT:  auto_exempt_q  <= cfg_i.data.value[0];
        CFG_HIGHEST_PORT: highest_port_q <= cfg_i.data.value[15:0];
        default: ;
      endcase
    end
  end

  // checks decided before any rule is looked at
  always_comb begin
    pre_done   = 1'b1;
    pre_status = STATUS_OK;
    if (!policy_en_q || in_d.proto_kind[1]) begin
      pre_status = STATUS_OK;
    end else if (!in_d.addr_family_ok) begin
      pre_status = STATUS_BAD_ADDR;
    end else if (auto_exempt_q && in_d.port == 16'd0 && !in_d.low_port_required) begin
      pre_status = STATUS_OK;
    end else if (in_d.port > highest_port_q) begin
      pre_status = STATUS_OK;
    end else begin
      pre_done = 1'b0;
    end
  end

  // rule storage
  assign wr_rule.proto    = in_d.proto_kind;
  assign wr_rule.is_group = in_d.id_kind;
  assign wr_rule.port     = in_d.port;
  assign wr_rule.jail     = in_d.jail_sel;
  assign wr_rule.subject  = in_d.subject_id;

  assign ram_we = in_xfer && (in_d.req_type == REQ_APPEND) && !table_full;

  pbpc_ram #(
    .Width (RULE_W),
    .Depth (MaxRules)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (wr_rule),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_rule)
  );

  pbpc_rule_match u_match (
    .rule_i (rd_rule),
    .req_i  (req_q),
    .hit_o  (hit)
  );

  // every address below the count has been issued; the last is compared in the same cycle
  assign scan_last = (idx_q >= cnt_q);
  assign fallback  = (priv_exempt_q && req_q.has_bind_privilege) ? STATUS_OK
                                                                  : STATUS_DENIED;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_d.req_type == REQ_CHECK && !pre_done) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if ((cmp_vld_q && hit) || scan_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  ;
      S_RESP:  out_load = !out_vld_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        case (in_d.req_type)
          REQ_APPEND: if (!table_full) cnt_q <= cnt_q + CntW'(1);
          REQ_CLEAR:  cnt_q <= '0;
          default: ;
        endcase
      end else if (state_q == S_SCAN) begin
        cmp_vld_q <= (idx_q < cnt_q);
        if (!scan_last) begin
          idx_q <= idx_q + CntW'(1);
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_d;
      case (in_d.req_type)
        REQ_CHECK:  status_q <= pre_status;
        REQ_APPEND: status_q <= table_full ? STATUS_FULL : STATUS_OK;
        default:    status_q <= STATUS_OK;
      endcase
    end else if (state_q == S_SCAN) begin
      if (cmp_vld_q && hit) begin
        status_q <= STATUS_OK;
      end else if (scan_last) begin
        status_q <= fallback;
      end
    end
    if (out_load) begin
      out_q.status     <= status_q;
      out_q.rules_held <= 7'(cnt_q);
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

### hw/rtl/pbpc_ram.sv
// ----------------------------------------------------------------------------
// pbpc_ram
// Generic memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pbpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pbpc_rule_match.sv
// ----------------------------------------------------------------------------
// pbpc_rule_match
// Compare unit: tests one stored rule against the held bind request.
// ----------------------------------------------------------------------------
module pbpc_rule_match (
  input  pbpc_pkg::rule_t    rule_i,
  input  pbpc_pkg::in_item_t req_i,
  output logic               hit_o
);
  import pbpc_pkg::*;

  logic proto_ok;
  logic jail_ok;
  logic id_ok;
  logic unjailed;

  assign unjailed = req_i.jail_sel[31];

  always_comb begin
    proto_ok = 1'b1;
    if (rule_i.proto != RPROTO_ANY) begin
      if (req_i.proto_kind == KIND_DGRAM && rule_i.proto != RPROTO_UDP) begin
        proto_ok = 1'b0;
      end
      if (req_i.proto_kind == KIND_STREAM && rule_i.proto != RPROTO_TCP) begin
        proto_ok = 1'b0;
      end
    end
  end

  always_comb begin
    if (rule_i.jail == JAIL_UNJAILED_ONLY) begin
      jail_ok = unjailed;
    end else if (rule_i.jail == JAIL_ANY) begin
      jail_ok = 1'b1;
    end else begin
      jail_ok = !unjailed && (req_i.jail_sel == rule_i.jail);
    end
  end

  // group rules see the primary and one supplementary group
  assign id_ok = rule_i.is_group ?
                 ((req_i.group_id == rule_i.subject) ||
                  (req_i.extra_group_id == rule_i.subject)) :
                 (req_i.subject_id == rule_i.subject);

  assign hit_o = proto_ok && (req_i.port == rule_i.port) && jail_ok && id_ok;

endmodule

### hw/rtl/pbpc_checker.sv
// ----------------------------------------------------------------------------
// pbpc_checker
// Port-level checks of the permission checker, bound to the top level.
// ----------------------------------------------------------------------------
module pbpc_checker #(
  parameter int unsigned MaxRules = pbpc_pkg::DEF_MAX_RULES
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input pbpc_pkg::out_item_t out_data_i
);
  import pbpc_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item in flight: no input transfer right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (MaxRules > 127) || (out_data_i.rules_held <= 7'(MaxRules)))
    else $error("rule count above capacity");

  // table full reported only with the table at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == STATUS_FULL |->
      out_data_i.rules_held == 7'(MaxRules))
    else $error("table full with room left");

endmodule

bind port_bind_permission_check pbpc_checker #(
  .MaxRules (MaxRules)
) u_pbpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
